@@ rtl/cell_spacing_rule_lookup_core_assert.svh @@
// assertion macros for the cell spacing rule lookup core
`ifndef CELL_SPACING_RULE_LOOKUP_CORE_ASSERT_SVH
`define CELL_SPACING_RULE_LOOKUP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define CSRL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csrl: assertion failed");
// checked on every edge, reset included
`define CSRL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("csrl: assertion failed");
`else
`define CSRL_ASSERT(lbl, clk, rst_n, prop)
`define CSRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/csrl_pkg.sv @@
`default_nettype none

package csrl_pkg;

    // sizes
    localparam int RULE_SLOTS = 16;
    localparam int EDGE_TYPES = 16;
    localparam int CELL_IDS   = 1024;
    localparam int GAP_BITS   = 16;

    localparam int SLOT_W = $clog2(RULE_SLOTS);
    localparam int EDGE_W = $clog2(EDGE_TYPES);
    localparam int CELL_W = $clog2(CELL_IDS);
    localparam int OUT_W  = GAP_BITS + 1;

    // rule slots are reduced in groups, one registered level per group stage
    localparam int GRP_SIZE = 4;
    localparam int GRP_NUM  = (RULE_SLOTS + GRP_SIZE - 1) / GRP_SIZE;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // command codes on the input beat
    localparam logic [1:0] CMD_RULE_WR = 2'd0;
    localparam logic [1:0] CMD_PAD_WR  = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_PAD   = 1'd1;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_RULE_WR,
        OP_PAD_WR,
        OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        MATCH_ANY,
        MATCH_LEFT,
        MATCH_RIGHT,
        MATCH_BOTH
    } match_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [SLOT_W-1:0]   table_slot;
        logic [EDGE_W-1:0]   edge_a;
        logic [EDGE_W-1:0]   edge_b;
        logic [GAP_BITS-1:0] rule_gap;
        logic [CELL_W-1:0]   left_cell;
        logic [CELL_W-1:0]   right_cell;
        logic                left_present;
        logic                right_present;
        logic [GAP_BITS-1:0] pad_left;
        logic [GAP_BITS-1:0] pad_right;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] required_gap;
        logic             is_answer;
    } out_item_t;

    // classified command as held in the queue
    typedef struct packed {
        op_t                 op;
        match_t              mode;
        logic [SLOT_W-1:0]   table_slot;
        logic [EDGE_W-1:0]   edge_a;
        logic [EDGE_W-1:0]   edge_b;
        logic [GAP_BITS-1:0] rule_gap;
        logic [CELL_W-1:0]   left_cell;
        logic [CELL_W-1:0]   right_cell;
        logic                left_present;
        logic                right_present;
        logic [GAP_BITS-1:0] pad_left;
        logic [GAP_BITS-1:0] pad_right;
    } q_item_t;

    // one padding memory word
    typedef struct packed {
        logic                valid;
        logic [GAP_BITS-1:0] pad_right;
        logic [GAP_BITS-1:0] pad_left;
    } pad_entry_t;

    // back end status seen by the front end
    typedef struct packed {
        logic clr_busy;
        logic pipe_busy;
    } back_status_t;

endpackage

`default_nettype wire

@@ rtl/cell_spacing_rule_lookup_core.sv @@
// Cell spacing rule lookup core.
// Input beats (s_valid/s_ready, s_data) carry one command each: write a
// spacing rule, write a cell's padding pair, or query the gap between two
// neighbouring cells. Every command returns exactly one beat on
// m_valid/m_ready; queries carry is_answer high, writes an acknowledge of 0.
// Configuration (cfg_we, cfg_index, cfg_wdata) sets the two enable bits; the
// user is to write it only while the core is idle, and nothing here enforces it.
// Path: an accepted beat passes the classify queue, the registered padding
// read with the grouped rule compare, the table reduction with padding add,
// and the output register before it shows on m_valid.
// Throughput: one beat per cycle while m_ready is high and no clear runs, limited
// by the single padding write port and the one-command-per-cycle issue.
// Reset: the rule table and the enables clear at once; the padding store is
// then cleared one entry a cycle, and s_ready stays low until every entry is cleared.
// A stalled receiver holds the whole back end; the four-entry command queue
// keeps taking beats until it fills, then s_ready drops.
`default_nettype none
`include "cell_spacing_rule_lookup_core_assert.svh"

module cell_spacing_rule_lookup_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [csrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire csrl_pkg::in_item_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output csrl_pkg::out_item_t                  m_data
);
    import csrl_pkg::*;

    back_status_t st;
    logic         q_push, q_full, q_pop, q_valid;
    q_item_t      q_in, q_out;

    // classify incoming beats
    csrl_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .st      (st),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    // decoupling queue
    csrl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out)
    );

    // table, padding store and result pipeline
    csrl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_out),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .st        (st)
    );

    // checks
    `CSRL_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `CSRL_ASSERT(a_clear_blocks_in, aclk, aresetn, st.clr_busy |-> !s_ready)
    `CSRL_ASSERT(a_clear_pipe_empty, aclk, aresetn, st.clr_busy |-> !st.pipe_busy && !m_valid)
    `CSRL_ASSERT(a_ack_zero_gap, aclk, aresetn, m_valid && !m_data.is_answer |-> m_data.required_gap == '0)

endmodule

`default_nettype wire

@@ rtl/csrl_front.sv @@
`default_nettype none

module csrl_front (
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire csrl_pkg::in_item_t     s_data,
    input  wire logic                   q_full,
    input  wire csrl_pkg::back_status_t st,
    output logic                        q_push,
    output csrl_pkg::q_item_t           q_item
);
    import csrl_pkg::*;

    // no beats while the padding store is being cleared
    assign s_ready = !q_full && !st.clr_busy;
    assign q_push  = s_valid && s_ready;

    // decode the command and the match mode
    always_comb begin
        q_item.table_slot    = s_data.table_slot;
        q_item.edge_a        = s_data.edge_a;
        q_item.edge_b        = s_data.edge_b;
        q_item.rule_gap      = s_data.rule_gap;
        q_item.left_cell     = s_data.left_cell;
        q_item.right_cell    = s_data.right_cell;
        q_item.left_present  = s_data.left_present;
        q_item.right_present = s_data.right_present;
        q_item.pad_left      = s_data.pad_left;
        q_item.pad_right     = s_data.pad_right;

        unique case (s_data.command)
            CMD_RULE_WR: q_item.op = OP_RULE_WR;
            CMD_PAD_WR:  q_item.op = OP_PAD_WR;
            CMD_QUERY:   q_item.op = OP_QUERY;
            default:     q_item.op = OP_NOP;
        endcase

        unique case ({s_data.left_present, s_data.right_present})
            2'b11:   q_item.mode = MATCH_BOTH;
            2'b10:   q_item.mode = MATCH_LEFT;
            2'b01:   q_item.mode = MATCH_RIGHT;
            default: q_item.mode = MATCH_ANY;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/csrl_queue.sv @@
`default_nettype none

module csrl_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire csrl_pkg::q_item_t push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output csrl_pkg::q_item_t      pop_item
);
    import csrl_pkg::*;

    q_item_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    // pointers wrap at the power-of-two depth
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (Q_PTR_W+1)'(1);
            2'b01:   count_next = count_reg - (Q_PTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/csrl_back.sv @@
`default_nettype none

module csrl_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [csrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csrl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                      q_valid,
    input  wire csrl_pkg::q_item_t         q_item,
    output logic                           q_pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output csrl_pkg::out_item_t            m_data,
    output csrl_pkg::back_status_t         st
);
    import csrl_pkg::*;

    // configuration
    logic use_table_reg, use_pad_reg;

    // rule table, one compare per slot
    logic [EDGE_W-1:0]   rule_first_reg  [RULE_SLOTS];
    logic [EDGE_W-1:0]   rule_second_reg [RULE_SLOTS];
    logic [GAP_BITS-1:0] rule_sep_reg    [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] rule_valid_reg;

    // padding store and its clearing pass
    pad_entry_t          pad_mem [CELL_IDS];
    logic                clr_busy_reg;
    logic [CELL_W-1:0]   clr_cnt_reg;
    logic                mem_we;
    logic [CELL_W-1:0]   mem_waddr;
    pad_entry_t          mem_wdata;

    // pipeline
    logic                adv, issue;
    logic [GAP_BITS-1:0] grp_next [GRP_NUM];
    logic                s1_valid_reg, s1_query_reg, s1_lp_reg, s1_rp_reg;
    logic [GAP_BITS-1:0] s1_grp_reg [GRP_NUM];
    pad_entry_t          s1_pad_l_reg, s1_pad_r_reg;
    logic                s2_valid_reg, s2_query_reg;
    logic [GAP_BITS-1:0] s2_tab_reg, s2_tab_next;
    logic [OUT_W-1:0]    s2_pad_reg, s2_pad_next;
    logic                m_valid_reg;
    out_item_t           m_data_reg, m_data_next;

    // whole back end moves together when the output slot frees up
    assign adv   = !m_valid_reg || m_ready;
    assign issue = adv && q_valid && !clr_busy_reg;
    assign q_pop = issue;

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign st.clr_busy  = clr_busy_reg;
    assign st.pipe_busy = s1_valid_reg || s2_valid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_table_reg <= 1'b0;
            use_pad_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_USE_TABLE: use_table_reg <= cfg_wdata[0];
                CFG_USE_PAD:   use_pad_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // rule table writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_valid_reg <= '0;
        end else if (issue && q_item.op == OP_RULE_WR) begin
            rule_valid_reg[q_item.table_slot] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && q_item.op == OP_RULE_WR) begin
            rule_first_reg[q_item.table_slot]  <= q_item.edge_a;
            rule_second_reg[q_item.table_slot] <= q_item.edge_b;
            rule_sep_reg[q_item.table_slot]    <= q_item.rule_gap;
        end
    end

    // clearing pass over the padding store after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + CELL_W'(1);
            if (clr_cnt_reg == CELL_W'(CELL_IDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // single write port shared by clearing and padding writes
    always_comb begin
        mem_we    = clr_busy_reg || (issue && q_item.op == OP_PAD_WR);
        mem_waddr = clr_busy_reg ? clr_cnt_reg : q_item.left_cell;
        if (clr_busy_reg) begin
            mem_wdata = '0;
        end else begin
            mem_wdata.valid     = 1'b1;
            mem_wdata.pad_right = q_item.pad_right;
            mem_wdata.pad_left  = q_item.pad_left;
        end
    end

    // padding store, two registered read ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pad_mem[mem_waddr] <= mem_wdata;
        end
        if (adv) begin
            s1_pad_l_reg <= pad_mem[q_item.left_cell];
            s1_pad_r_reg <= pad_mem[q_item.right_cell];
        end
    end

    // slot match and per-group maximum
    always_comb begin
        logic hit;
        int   idx;
        for (int g = 0; g < GRP_NUM; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                idx = g * GRP_SIZE + k;
                hit = 1'b0;
                if (idx < RULE_SLOTS) begin
                    unique case (q_item.mode)
                        MATCH_BOTH:  hit = (rule_first_reg[idx] == q_item.edge_a &&
                                            rule_second_reg[idx] == q_item.edge_b) ||
                                           (rule_first_reg[idx] == q_item.edge_b &&
                                            rule_second_reg[idx] == q_item.edge_a);
                        MATCH_LEFT:  hit = rule_first_reg[idx] == q_item.edge_a ||
                                           rule_second_reg[idx] == q_item.edge_a;
                        MATCH_RIGHT: hit = rule_first_reg[idx] == q_item.edge_b ||
                                           rule_second_reg[idx] == q_item.edge_b;
                        default:     hit = 1'b1;
                    endcase
                    if (hit && rule_valid_reg[idx] && rule_sep_reg[idx] > grp_next[g]) begin
                        grp_next[g] = rule_sep_reg[idx];
                    end
                end
            end
        end
    end

    // stage one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_query_reg <= issue && q_item.op == OP_QUERY;
            s1_lp_reg    <= q_item.left_present;
            s1_rp_reg    <= q_item.right_present;
            for (int g = 0; g < GRP_NUM; g++) begin
                s1_grp_reg[g] <= grp_next[g];
            end
        end
    end

    // stage two: table maximum and padding sum
    always_comb begin
        logic [GAP_BITS-1:0] l_part, r_part;
        s2_tab_next = '0;
        for (int g = 0; g < GRP_NUM; g++) begin
            if (s1_grp_reg[g] > s2_tab_next) begin
                s2_tab_next = s1_grp_reg[g];
            end
        end
        l_part = (s1_lp_reg && s1_pad_l_reg.valid) ? s1_pad_l_reg.pad_right : '0;
        r_part = (s1_rp_reg && s1_pad_r_reg.valid) ? s1_pad_r_reg.pad_left : '0;
        s2_pad_next = {1'b0, l_part} + {1'b0, r_part};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_query_reg <= s1_query_reg;
            s2_tab_reg   <= s2_tab_next;
            s2_pad_reg   <= s2_pad_next;
        end
    end

    // stage three: combine enabled parts into the output register
    always_comb begin
        logic [OUT_W-1:0] tab_part, pad_part;
        tab_part = use_table_reg ? {1'b0, s2_tab_reg} : '0;
        pad_part = use_pad_reg ? s2_pad_reg : '0;
        if (s2_query_reg) begin
            m_data_next.required_gap = (tab_part > pad_part) ? tab_part : pad_part;
            m_data_next.is_answer    = 1'b1;
        end else begin
            m_data_next.required_gap = '0;
            m_data_next.is_answer    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
